/* design/bag_pkg.sv */
`timescale 1ns / 1ps

package bag_pkg;

  localparam int GRID_W_DEF = 256;
  localparam int GRID_H_DEF = 256;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_GEN   = 2'd3;

  localparam logic [1:0] ST_READY      = 2'd0;
  localparam logic [1:0] ST_FIRING     = 2'd1;
  localparam logic [1:0] ST_REFRACTORY = 2'd2;

  // Next state of one cell from its old state and its count of firing neighbours
  function automatic logic [1:0] next_cell(input logic [1:0] old, input logic [3:0] fired);
    logic [1:0] nxt;
    if (old == ST_READY && fired == 4'd2) begin
      nxt = ST_FIRING;
    end else if (old == ST_FIRING) begin
      nxt = ST_REFRACTORY;
    end else begin
      nxt = ST_READY;
    end
    return nxt;
  endfunction

endpackage

/* design/bag_ram.sv */
`timescale 1ns / 1ps

module bag_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/brain_automaton_generation.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// request   in         start high, busy low       cmd, col, row, cell_value
// result    out        result_valid, one cycle    cell_state, op_done
//
// Write and read: the result shows in the cycle after acceptance, and busy stays high through it.
// Clear: one cell per cycle through the grid memory write port.
// Generation: a preload of the old last row and old row 0, then a row-by-row sweep paced by
// the single grid memory read port, then a pipeline drain.
// Reset runs a clearing pass over every cell with busy high and no result.
// The receiver cannot stall: each result shows for exactly one cycle.

module brain_automaton_generation #(
  parameter int GRID_W = bag_pkg::GRID_W_DEF,
  parameter int GRID_H = bag_pkg::GRID_H_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [7:0] col,
  input  logic [7:0] row,
  input  logic [1:0] cell_value,
  output logic       result_valid,
  output logic [1:0] cell_state,
  output logic       op_done
);

  localparam int CELLS = GRID_W * GRID_H;
  localparam int CW    = $clog2(GRID_W);
  localparam int RW    = $clog2(GRID_H);
  localparam int GA    = $clog2(CELLS);
  localparam int KW    = $clog2(GRID_W + 2);
  localparam int PW    = $clog2(2 * GRID_W + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RESP  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_PRE   = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;

  logic [2:0]    state;
  logic          clr_silent;
  logic          resp_read;
  logic [GA-1:0] clr_addr;
  logic [GA-1:0] rd_base;
  logic [GA-1:0] wr_addr;
  logic [PW-1:0] pre_cnt;
  logic [RW-1:0] y;
  logic [KW-1:0] k;
  logic [1:0]    up_id;
  logic [1:0]    cur_id;
  logic [1:0]    dn_id;

  logic          p1_v;
  logic          p1_second;
  logic [CW-1:0] p1_col;
  logic          s1_v;
  logic          s1_last;
  logic [KW-1:0] s1_k;
  logic [CW-1:0] s1_col;
  logic [1:0]    s1_up_id;
  logic [1:0]    s1_cur_id;
  logic [1:0]    s1_dn_id;
  logic          s2_v;

  logic [1:0] win_up  [3];
  logic [1:0] win_cur [3];
  logic [1:0] win_dn  [3];

  logic          accept;
  logic          in_grid;
  logic [GA-1:0] port_addr;
  logic [CW-1:0] sw_col;
  logic          sw_last;
  logic          pre_issue;
  logic          pre_second;
  logic [CW-1:0] pre_col;
  logic [GA-1:0] pre_addr;

  logic          g_we;
  logic [GA-1:0] g_waddr;
  logic [1:0]    g_wdata;
  logic [GA-1:0] g_raddr;
  logic [1:0]    grid_rd;

  logic          line_we [3];
  logic [CW-1:0] line_waddr;
  logic [1:0]    line_rd [3];
  logic          first_we;
  logic [1:0]    first_rd;

  logic [1:0] up_new;
  logic [1:0] cur_new;
  logic [1:0] dn_new;
  logic [3:0] fired;
  logic [1:0] new_cell;

  function automatic logic [1:0] pick3(input logic [1:0] id, input logic [1:0] a,
                                       input logic [1:0] b, input logic [1:0] c);
    logic [1:0] v;
    case (id)
      2'd0:    v = a;
      2'd1:    v = b;
      default: v = c;
    endcase
    return v;
  endfunction

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_RESP);
  assign op_done      = result_valid;
  assign cell_state   = (result_valid && resp_read) ? grid_rd : bag_pkg::ST_READY;

  assign accept    = start && !busy;
  assign in_grid   = (32'(col) < GRID_W) && (32'(row) < GRID_H);
  assign port_addr = GA'(32'(row) * GRID_W + 32'(col));

  // Each row is read as column W-1, 0 .. W-1, 0 so the window wraps at the edges
  always_comb begin
    if (k == '0) begin
      sw_col = CW'(GRID_W - 1);
    end else if (k == KW'(GRID_W + 1)) begin
      sw_col = '0;
    end else begin
      sw_col = CW'(k - KW'(1));
    end
  end

  assign sw_last    = (y == RW'(GRID_H - 1));
  assign pre_issue  = (state == S_PRE) && (pre_cnt < PW'(2 * GRID_W));
  assign pre_second = (pre_cnt >= PW'(GRID_W));
  assign pre_col    = pre_second ? CW'(pre_cnt - PW'(GRID_W)) : CW'(pre_cnt);
  // Preload the old last row first, then the old row 0
  assign pre_addr   = pre_second ? GA'(pre_col)
                                 : GA'((GRID_H - 1) * GRID_W) + GA'(pre_col);

  always_comb begin
    case (state)
      S_IDLE:  g_raddr = port_addr;
      S_PRE:   g_raddr = pre_addr;
      S_SWEEP: g_raddr = rd_base + GA'(sw_col);
      default: g_raddr = '0;
    endcase
  end

  always_comb begin
    case (state)
      S_IDLE: begin
        g_we    = accept && (cmd == bag_pkg::CMD_WRITE) && in_grid;
        g_waddr = port_addr;
        g_wdata = cell_value;
      end
      S_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_addr;
        g_wdata = bag_pkg::ST_READY;
      end
      S_SWEEP, S_DRAIN: begin
        g_we    = s2_v;
        g_waddr = wr_addr;
        g_wdata = new_cell;
      end
      default: begin
        g_we    = 1'b0;
        g_waddr = wr_addr;
        g_wdata = new_cell;
      end
    endcase
  end

  bag_ram #(
    .DEPTH (CELLS),
    .WIDTH (2)
  ) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (grid_rd)
  );

  assign line_waddr = p1_v ? p1_col : s1_col;
  assign first_we   = p1_v && p1_second;

  for (genvar i = 0; i < 3; i++) begin : g_line
    assign line_we[i] = (p1_v && (p1_second ? (i == 1) : (i == 0)))
                     || (s1_v && !s1_last && (s1_dn_id == 2'(i)));

    bag_ram #(
      .DEPTH (GRID_W),
      .WIDTH (2)
    ) u_line (
      .clk   (clk),
      .we    (line_we[i]),
      .waddr (line_waddr),
      .wdata (grid_rd),
      .raddr (sw_col),
      .rdata (line_rd[i])
    );
  end

  bag_ram #(
    .DEPTH (GRID_W),
    .WIDTH (2)
  ) u_first (
    .clk   (clk),
    .we    (first_we),
    .waddr (p1_col),
    .wdata (grid_rd),
    .raddr (sw_col),
    .rdata (first_rd)
  );

  assign up_new  = pick3(s1_up_id, line_rd[0], line_rd[1], line_rd[2]);
  assign cur_new = pick3(s1_cur_id, line_rd[0], line_rd[1], line_rd[2]);
  // The last row takes the old row 0 from its saved copy
  assign dn_new  = s1_last ? first_rd : grid_rd;

  assign fired = 4'(win_up[0] == bag_pkg::ST_FIRING) + 4'(win_up[1] == bag_pkg::ST_FIRING)
               + 4'(win_up[2] == bag_pkg::ST_FIRING) + 4'(win_dn[0] == bag_pkg::ST_FIRING)
               + 4'(win_dn[1] == bag_pkg::ST_FIRING) + 4'(win_dn[2] == bag_pkg::ST_FIRING)
               + 4'(win_cur[0] == bag_pkg::ST_FIRING)
               + 4'(win_cur[2] == bag_pkg::ST_FIRING);

  assign new_cell = bag_pkg::next_cell(win_cur[1], fired);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_silent <= 1'b1;
      resp_read  <= 1'b0;
      p1_v       <= 1'b0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      pre_cnt    <= '0;
      y          <= '0;
      k          <= '0;
      rd_base    <= '0;
      wr_addr    <= '0;
      up_id      <= 2'd0;
      cur_id     <= 2'd1;
      dn_id      <= 2'd2;
    end else begin
      p1_v <= pre_issue;
      s1_v <= (state == S_SWEEP);
      s2_v <= s1_v && (s1_k >= KW'(2));
      if (s2_v) begin
        wr_addr <= wr_addr + GA'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            resp_read <= 1'b0;
            case (cmd)
              bag_pkg::CMD_WRITE: begin
                state <= S_RESP;
              end
              bag_pkg::CMD_READ: begin
                state     <= S_RESP;
                resp_read <= in_grid;
              end
              bag_pkg::CMD_CLEAR: begin
                state      <= S_CLEAR;
                clr_addr   <= '0;
                clr_silent <= 1'b0;
              end
              bag_pkg::CMD_GEN: begin
                state   <= S_PRE;
                pre_cnt <= '0;
                y       <= '0;
                k       <= '0;
                rd_base <= GA'(GRID_W);
                wr_addr <= '0;
                up_id   <= 2'd0;
                cur_id  <= 2'd1;
                dn_id   <= 2'd2;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_RESP: begin
          state <= S_IDLE;
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + GA'(1);
          if (clr_addr == GA'(CELLS - 1)) begin
            state <= clr_silent ? S_IDLE : S_RESP;
          end
        end
        S_PRE: begin
          pre_cnt <= pre_cnt + PW'(1);
          // Holding S_PRE past the last issue lets the last buffer write land before the sweep reads
          if (pre_cnt == PW'(2 * GRID_W)) begin
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (k == KW'(GRID_W + 1)) begin
            k      <= '0;
            up_id  <= cur_id;
            cur_id <= dn_id;
            dn_id  <= up_id;
            if (sw_last) begin
              state <= S_DRAIN;
            end else begin
              y       <= y + RW'(1);
              rd_base <= rd_base + GA'(GRID_W);
            end
          end else begin
            k <= k + KW'(1);
          end
        end
        S_DRAIN: begin
          if (!s1_v && !s2_v) begin
            state <= S_RESP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p1_second <= pre_second;
    p1_col    <= pre_col;
    s1_last   <= sw_last;
    s1_k      <= k;
    s1_col    <= sw_col;
    s1_up_id  <= up_id;
    s1_cur_id <= cur_id;
    s1_dn_id  <= dn_id;
    if (s1_v) begin
      win_up[0]  <= win_up[1];
      win_up[1]  <= win_up[2];
      win_up[2]  <= up_new;
      win_cur[0] <= win_cur[1];
      win_cur[1] <= win_cur[2];
      win_cur[2] <= cur_new;
      win_dn[0]  <= win_dn[1];
      win_dn[1]  <= win_dn[2];
      win_dn[2]  <= dn_new;
    end
  end

endmodule

/* design/bag_checker.sv */
`timescale 1ns / 1ps

module bag_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] cmd,
  input logic [7:0] col,
  input logic [7:0] row,
  input logic [1:0] cell_value,
  input logic       result_valid,
  input logic [1:0] cell_state,
  input logic       op_done
);

  logic accepted;
  assign accepted = start && !busy;

  // A taken request holds the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accepted |=> busy)
    else $error("busy low after an accepted request");

  // Single cell requests answer in the next cycle
  a_cell_cmd_answers: assert property (@(posedge clk) disable iff (rst)
    accepted && (cmd == bag_pkg::CMD_WRITE || cmd == bag_pkg::CMD_READ) |=> result_valid)
    else $error("write or read request without a result in the next cycle");

  // Strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  // Strobe and completion flag agree
  a_done_marks_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> op_done)
    else $error("result without op_done");

  // Cell state stays quiet between results
  a_state_quiet: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> (cell_state == bag_pkg::ST_READY) && !op_done)
    else $error("result fields active outside a result cycle");

endmodule

bind brain_automaton_generation bag_checker u_bag_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int GW = bag_pkg::GRID_W_DEF;
  localparam int GH = bag_pkg::GRID_H_DEF;
  localparam int RAND_ITEMS = 65;
  localparam int CALM_AFTER = 75;
  localparam logic [1:0] ST_CLEARABLE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] val;
    logic       fixed;
    logic [1:0] want;
  } req_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] cmd = bag_pkg::CMD_READ;
  logic [7:0] col = 8'd0;
  logic [7:0] row = 8'd0;
  logic [1:0] cell_value = bag_pkg::ST_READY;
  logic       busy;
  logic       result_valid;
  logic [1:0] cell_state;
  logic       op_done;

  // travels with each request: a state read off by hand, used instead of the prediction
  logic       fixed_valid = 1'b0;
  logic [1:0] fixed_state = bag_pkg::ST_READY;

  logic [1:0] cell_map [0:GH-1][0:GW-1];
  logic [1:0] cell_map_next [0:GH-1][0:GW-1];
  logic [1:0] due_states [$];
  req_row_t   directed_reqs [$];
  int         sent = 0;
  bit         failed = 1'b0;

  brain_automaton_generation uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .col(col),
    .row(row),
    .cell_value(cell_value),
    .result_valid(result_valid),
    .cell_state(cell_state),
    .op_done(op_done)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void clear_map();
    int x, y;
    for (y = 0; y < GH; y++) begin
      for (x = 0; x < GW; x++) begin
        cell_map[y][x] = bag_pkg::ST_READY;
      end
    end
  endfunction

  // All cells update together from the old grid; neighbours wrap round the torus
  function automatic void advance_generation();
    int x, y, dx, dy, n;
    logic [1:0] old;
    for (y = 0; y < GH; y++) begin
      for (x = 0; x < GW; x++) begin
        n = 0;
        for (dy = -1; dy <= 1; dy++) begin
          for (dx = -1; dx <= 1; dx++) begin
            if ((dx != 0 || dy != 0) &&
                cell_map[(y + dy + GH) % GH][(x + dx + GW) % GW] == bag_pkg::ST_FIRING) begin
              n++;
            end
          end
        end
        old = cell_map[y][x];
        if (old == bag_pkg::ST_READY && n == 2) begin
          cell_map_next[y][x] = bag_pkg::ST_FIRING;
        end else if (old == bag_pkg::ST_FIRING) begin
          cell_map_next[y][x] = bag_pkg::ST_REFRACTORY;
        end else begin
          cell_map_next[y][x] = bag_pkg::ST_READY;
        end
      end
    end
    for (y = 0; y < GH; y++) begin
      for (x = 0; x < GW; x++) begin
        cell_map[y][x] = cell_map_next[y][x];
      end
    end
  endfunction

  function automatic logic [1:0] apply_request(input logic [1:0] op, input logic [7:0] x,
                                               input logic [7:0] y, input logic [1:0] val);
    logic [1:0] got;
    got = bag_pkg::ST_READY;
    case (op)
      bag_pkg::CMD_WRITE: cell_map[y][x] = val;
      bag_pkg::CMD_READ:  got = cell_map[y][x];
      bag_pkg::CMD_CLEAR: clear_map();
      default:            advance_generation();
    endcase
    return got;
  endfunction

  always @(posedge clk) begin : check_results
    logic [1:0] got, want;
    if (result_valid) begin
      if (due_states.size() == 0) begin
        $display("%0t: result with none due, cell_state %0d op_done %0d",
                 $time, cell_state, op_done);
        failed = 1'b1;
      end else begin
        want = due_states.pop_front();
        if (cell_state !== want) begin
          $display("%0t: cell_state expected %0d, got %0d", $time, want, cell_state);
          failed = 1'b1;
        end
        if (op_done !== 1'b1) begin
          $display("%0t: op_done expected 1, got %0d", $time, op_done);
          failed = 1'b1;
        end
      end
    end
    if (!rst && start && !busy) begin
      got = apply_request(cmd, col, row, cell_value);
      due_states.push_back(fixed_valid ? fixed_state : got);
    end
  end

  function automatic req_row_t mk(input logic [1:0] op, input logic [7:0] x, input logic [7:0] y,
                                  input logic [1:0] val, input logic fixed,
                                  input logic [1:0] want);
    req_row_t r;
    r.op = op;
    r.x = x;
    r.y = y;
    r.val = val;
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  // Optionally pause with noise on the fields, then hold the request until accepted
  task automatic issue_request(input logic [1:0] op, input logic [7:0] x, input logic [7:0] y,
                               input logic [1:0] val, input logic fixed, input logic [1:0] want);
    if (sent < CALM_AFTER && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      cmd <= 2'($urandom_range(0, 3));
      col <= 8'($urandom_range(0, 255));
      row <= 8'($urandom_range(0, 255));
      cell_value <= 2'($urandom_range(0, 3));
      fixed_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    col <= x;
    row <= y;
    cell_value <= val;
    fixed_valid <= fixed;
    fixed_state <= want;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  initial begin : drive
    logic [7:0] cx, cy, x, y;
    logic [1:0] v;
    int gens_left, clears_left, i;
    clear_map();
    gens_left = 8;
    clears_left = 2;

    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd0,   8'd0,   bag_pkg::ST_READY,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd255, 8'd255, ST_CLEARABLE,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_WRITE, 8'd0,   8'd0,   bag_pkg::ST_FIRING,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd0,   8'd0,   bag_pkg::ST_READY,
                               1'b1, bag_pkg::ST_FIRING));
    directed_reqs.push_back(mk(bag_pkg::CMD_WRITE, 8'd1,   8'd0,   bag_pkg::ST_FIRING,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_WRITE, 8'd255, 8'd255, ST_CLEARABLE,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd255, 8'd255, bag_pkg::ST_READY,
                               1'b1, ST_CLEARABLE));
    directed_reqs.push_back(mk(bag_pkg::CMD_WRITE, 8'd255, 8'd0,   bag_pkg::ST_REFRACTORY,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd255, 8'd0,   bag_pkg::ST_READY,
                               1'b1, bag_pkg::ST_REFRACTORY));
    directed_reqs.push_back(mk(bag_pkg::CMD_WRITE, 8'd128, 8'd127, bag_pkg::ST_FIRING,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_WRITE, 8'd127, 8'd128, bag_pkg::ST_FIRING,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_GEN,   8'd0,   8'd0,   bag_pkg::ST_READY,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd0,   8'd0,   bag_pkg::ST_READY,
                               1'b1, bag_pkg::ST_REFRACTORY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd255, 8'd255, bag_pkg::ST_READY,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd255, 8'd0,   bag_pkg::ST_READY,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd0,   8'd1,   bag_pkg::ST_READY,
                               1'b0, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd1,   8'd255, bag_pkg::ST_READY,
                               1'b0, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd128, 8'd128, bag_pkg::ST_READY,
                               1'b0, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd127, 8'd127, bag_pkg::ST_READY,
                               1'b0, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_GEN,   8'd255, 8'd255, ST_CLEARABLE,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd0,   8'd0,   bag_pkg::ST_READY,
                               1'b0, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd128, 8'd128, bag_pkg::ST_READY,
                               1'b0, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_CLEAR, 8'd17,  8'd34,  bag_pkg::ST_FIRING,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd128, 8'd128, bag_pkg::ST_READY,
                               1'b1, bag_pkg::ST_READY));
    directed_reqs.push_back(mk(bag_pkg::CMD_READ,  8'd1,   8'd255, bag_pkg::ST_READY,
                               1'b1, bag_pkg::ST_READY));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed_reqs.size(); i++) begin
      issue_request(directed_reqs[i].op, directed_reqs[i].x, directed_reqs[i].y,
                    directed_reqs[i].val, directed_reqs[i].fixed, directed_reqs[i].want);
    end

    // Seed a small patch, often near an edge or corner, let it evolve, then probe it
    while (sent < directed_reqs.size() + RAND_ITEMS) begin
      cx = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                : ($urandom_range(0, 1) ? 8'd255 : 8'd0);
      cy = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                : ($urandom_range(0, 1) ? 8'd255 : 8'd0);
      repeat ($urandom_range(3, 10)) begin
        x = cx + 8'($urandom_range(0, 4)) - 8'd2;
        y = cy + 8'($urandom_range(0, 4)) - 8'd2;
        v = ($urandom_range(0, 9) < 6) ? bag_pkg::ST_FIRING : 2'($urandom_range(0, 3));
        issue_request(bag_pkg::CMD_WRITE, x, y, v, 1'b0, bag_pkg::ST_READY);
      end
      if ($urandom_range(0, 4) == 0) begin
        issue_request(bag_pkg::CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      2'($urandom_range(0, 3)), 1'b0, bag_pkg::ST_READY);
      end
      repeat ($urandom_range(1, 2)) begin
        if (gens_left > 0) begin
          gens_left--;
          issue_request(bag_pkg::CMD_GEN, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                        1'b0, bag_pkg::ST_READY);
        end
        repeat ($urandom_range(3, 8)) begin
          x = cx + 8'($urandom_range(0, 6)) - 8'd3;
          y = cy + 8'($urandom_range(0, 6)) - 8'd3;
          issue_request(bag_pkg::CMD_READ, x, y, 2'($urandom_range(0, 3)),
                        1'b0, bag_pkg::ST_READY);
        end
      end
      if (clears_left > 0 && $urandom_range(0, 9) == 0) begin
        clears_left--;
        issue_request(bag_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                      1'b0, bag_pkg::ST_READY);
      end
    end
    start <= 1'b0;

    // Let the last request reach the queue before waiting for it to drain
    @(posedge clk);
    while (due_states.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
